// ===== rtl/rwlm_pkg.sv =====
// Shared types and constants for the reader-writer lock manager.
package rwlm_pkg;

   localparam logic [1:0] ACT_NEW     = 2'd0;
   localparam logic [1:0] ACT_ACQUIRE = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_QUEUED   = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTHELD  = 3'd4;

   localparam logic KIND_FINAL = 1'b0;
   localparam logic KIND_WAKE  = 1'b1;

   localparam logic [8:0] RC_MAX = 9'd511;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] lock_id;
      logic       lock_mode;
      logic [7:0] process_id;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [2:0] status;
      logic [4:0] result_lock;
      logic [7:0] woken_process;
      logic       woken_mode;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_LOOK,
      BE_DRAIN,
      BE_FINAL
   } be_state_type;

endpackage

// ===== rtl/rwlm_front.sv =====
// Front end: accepts request beats into a short queue toward the back end.
module rwlm_front #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rwlm_pkg::req_type req_data,
   output logic              q_valid,
   input  logic              q_take,
   output rwlm_pkg::req_type q_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rwlm_pkg::req_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign req_stall = (cnt_ff == (AW+1)'(DEPTH));
   assign push = req_valid && !req_stall;
   assign pop  = q_take && q_valid;
   assign q_valid = (cnt_ff != '0);
   assign q_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= req_data;
      end
   end
endmodule

// ===== rtl/rwlm_back.sv =====
// Back end: lock table, waiter queues and result sequencing.
module rwlm_back #(
   parameter int NUM_LOCKS   = 16,
   parameter int QUEUE_DEPTH = 8,
   parameter int PID_BITS    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_take,
   input  rwlm_pkg::req_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rwlm_pkg::rsp_type rsp_data
);
   localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int NW = $clog2(NUM_LOCKS + 1);
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int MD = NUM_LOCKS * QUEUE_DEPTH;
   localparam int MW = (MD > 1) ? $clog2(MD) : 1;

   rwlm_pkg::be_state_type st_ff, st_in;

   logic [NW-1:0] nlock_ff, nlock_in;
   logic [8:0]    rc_ff [NUM_LOCKS];
   logic          wh_ff [NUM_LOCKS];
   logic [QW-1:0] wh_head_ff [NUM_LOCKS];
   logic [CW-1:0] wc_ff [NUM_LOCKS];
   logic [QW-1:0] rd_head_ff [NUM_LOCKS];
   logic [CW-1:0] rcnt_ff [NUM_LOCKS];
   logic [PID_BITS-1:0] wq_mem [MD];
   logic [PID_BITS-1:0] rq_mem [MD];
   logic [PID_BITS-1:0] rq_rd_ff, wq_rd_ff;

   rwlm_pkg::req_type cur_ff;
   logic [LW-1:0]     ix_ff;

   rwlm_pkg::rsp_type out_ff;
   logic              out_v_ff;
   logic              out_free;

   // Decoded view of the current request (registered at take).
   logic          found;
   logic [LW-1:0] ix_w;
   logic [LW-1:0] ix_q, ix_rd;
   logic [8:0]    rc_c;
   logic [8:0]    rc_base;
   logic          wh_c;
   logic [CW-1:0] wc_c, rcn_c;
   logic [QW-1:0] wh_h, rd_h;
   logic [QW-1:0] w_tail, r_tail;

   assign out_free = !out_v_ff || !rsp_stall;
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;
   assign q_take = (st_ff == rwlm_pkg::BE_IDLE) && q_valid;

   assign ix_w  = LW'(cur_ff.lock_id - 5'd1);
   assign ix_q  = LW'(q_data.lock_id - 5'd1);
   assign ix_rd = (st_ff == rwlm_pkg::BE_IDLE) ? ix_q : ix_w;
   assign found = (cur_ff.lock_id != 5'd0) && ({27'd0, cur_ff.lock_id} <= 32'(nlock_ff));
   assign rc_c  = rc_ff[ix_ff];
   assign wc_c  = wc_ff[ix_ff];
   assign wh_c  = wh_ff[ix_ff];
   assign rcn_c = rcnt_ff[ix_ff];
   assign wh_h  = wh_head_ff[ix_ff];
   assign rd_h  = rd_head_ff[ix_ff];

   function automatic logic [QW-1:0] qadd(input logic [QW-1:0] h, input logic [CW-1:0] c);
      logic [QW+CW:0] s;
      s = (QW+CW+1)'(h) + (QW+CW+1)'(c);
      if (s >= (QW+CW+1)'(QUEUE_DEPTH)) begin
         s = s - (QW+CW+1)'(QUEUE_DEPTH);
      end
      return QW'(s);
   endfunction

   assign w_tail = qadd(wh_h, wc_c);
   assign r_tail = qadd(rd_h, rcn_c);

   function automatic logic [MW-1:0] maddr(input logic [LW-1:0] i, input logic [QW-1:0] p);
      return MW'(32'(i) * QUEUE_DEPTH + 32'(p));
   endfunction

   // Look-stage decisions.
   logic       lk_fin, lk_wake_w, lk_drain;
   logic [2:0] lk_status;
   logic       lk_enq_w, lk_enq_r, lk_rc_inc, lk_rc_dec, lk_wh_set, lk_wh_clr;
   logic       lk_new;
   logic       freed;

   always_comb begin
      lk_status = rwlm_pkg::ST_OK;
      lk_enq_w = 1'b0; lk_enq_r = 1'b0; lk_rc_inc = 1'b0; lk_rc_dec = 1'b0;
      lk_wh_set = 1'b0; lk_wh_clr = 1'b0; lk_new = 1'b0;
      lk_wake_w = 1'b0; lk_drain = 1'b0; freed = 1'b0;
      lk_fin = 1'b1;
      if (cur_ff.action == rwlm_pkg::ACT_NEW) begin
         if (32'(nlock_ff) >= NUM_LOCKS) begin
            lk_status = rwlm_pkg::ST_FULL;
         end else begin
            lk_new = 1'b1;
         end
      end else if (cur_ff.action != rwlm_pkg::ACT_ACQUIRE &&
                   cur_ff.action != rwlm_pkg::ACT_RELEASE) begin
         lk_status = rwlm_pkg::ST_FULL;
      end else if (!found) begin
         lk_status = rwlm_pkg::ST_NOTFOUND;
      end else if (cur_ff.action == rwlm_pkg::ACT_ACQUIRE) begin
         if (wh_c || wc_c != '0 || (cur_ff.lock_mode && rc_c != 9'd0)) begin
            if (cur_ff.lock_mode) begin
               if (32'(wc_c) >= QUEUE_DEPTH) lk_status = rwlm_pkg::ST_FULL;
               else begin lk_status = rwlm_pkg::ST_QUEUED; lk_enq_w = 1'b1; end
            end else begin
               if (32'(rcn_c) >= QUEUE_DEPTH) lk_status = rwlm_pkg::ST_FULL;
               else begin lk_status = rwlm_pkg::ST_QUEUED; lk_enq_r = 1'b1; end
            end
         end else if (!cur_ff.lock_mode) begin
            if (rc_c >= rwlm_pkg::RC_MAX) lk_status = rwlm_pkg::ST_FULL;
            else lk_rc_inc = 1'b1;
         end else begin
            lk_wh_set = 1'b1;
         end
      end else begin
         if (!cur_ff.lock_mode) begin
            if (rc_c == 9'd0) lk_status = rwlm_pkg::ST_NOTHELD;
            else begin
               lk_rc_dec = 1'b1;
               freed = (rc_c == 9'd1) && !wh_c;
            end
         end else begin
            if (!wh_c) lk_status = rwlm_pkg::ST_NOTHELD;
            else begin
               lk_wh_clr = 1'b1;
               freed = (rc_c == 9'd0);
            end
         end
         if (freed) begin
            if (wc_c != '0) begin
               lk_wake_w = 1'b1;
               lk_fin = 1'b0;
            end else if (rcn_c != '0) begin
               lk_drain = 1'b1;
               lk_fin = 1'b0;
            end
         end
      end
   end

   assign rc_base = (st_ff == rwlm_pkg::BE_LOOK && lk_rc_dec) ? rc_c - 9'd1 : rc_c;

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         rwlm_pkg::BE_IDLE:  if (q_valid) st_in = rwlm_pkg::BE_LOOK;
         rwlm_pkg::BE_LOOK: begin
            if (out_free) begin
               priority if (lk_fin) st_in = rwlm_pkg::BE_IDLE;
               else if (lk_wake_w || rcn_c == CW'(1)) st_in = rwlm_pkg::BE_FINAL;
               else st_in = rwlm_pkg::BE_DRAIN;
            end
         end
         rwlm_pkg::BE_DRAIN: if (out_free && rcn_c == CW'(1)) st_in = rwlm_pkg::BE_FINAL;
         rwlm_pkg::BE_FINAL: if (out_free) st_in = rwlm_pkg::BE_IDLE;
         default: st_in = rwlm_pkg::BE_IDLE;
      endcase
   end

   // Output beat and table updates.
   rwlm_pkg::rsp_type out_in;
   logic              out_v_in;
   logic              load;

   always_comb begin
      out_in = out_ff;
      out_v_in = out_v_ff && rsp_stall;
      load = 1'b0;
      nlock_in = nlock_ff;
      unique case (st_ff)
         rwlm_pkg::BE_LOOK: begin
            if (out_free) begin
               load = 1'b1;
               if (lk_new) nlock_in = nlock_ff + 1'b1;
               if (lk_wake_w) begin
                  out_in = '{rwlm_pkg::KIND_WAKE, rwlm_pkg::ST_OK, cur_ff.lock_id,
                             8'(wq_rd_ff), 1'b1, 1'b0};
               end else if (lk_drain) begin
                  out_in = '{rwlm_pkg::KIND_WAKE, rwlm_pkg::ST_OK, cur_ff.lock_id,
                             8'(rq_rd_ff), 1'b0, 1'b0};
               end else begin
                  out_in = '{rwlm_pkg::KIND_FINAL, lk_status,
                             lk_new ? 5'(nlock_in) :
                             (cur_ff.action == rwlm_pkg::ACT_NEW ? 5'd0 : cur_ff.lock_id),
                             8'd0, 1'b0, 1'b1};
               end
            end
         end
         rwlm_pkg::BE_DRAIN: begin
            if (out_free) begin
               load = 1'b1;
               out_in = '{rwlm_pkg::KIND_WAKE, rwlm_pkg::ST_OK, cur_ff.lock_id,
                          8'(rq_rd_ff), 1'b0, 1'b0};
            end
         end
         rwlm_pkg::BE_FINAL: begin
            if (out_free) begin
               load = 1'b1;
               out_in = '{rwlm_pkg::KIND_FINAL, rwlm_pkg::ST_OK, cur_ff.lock_id,
                          8'd0, 1'b0, 1'b1};
            end
         end
         default: ;
      endcase
      if (load) out_v_in = 1'b1;
   end

   // Queue read ports: head of the addressed lock, or next reader while draining.
   logic [QW-1:0] rd_next;
   assign rd_next = (rd_h == QW'(QUEUE_DEPTH-1)) ? '0 : rd_h + 1'b1;

   always_ff @(posedge clock) begin
      if (st_ff == rwlm_pkg::BE_IDLE) begin
         cur_ff <= q_data;
         ix_ff  <= ix_q;
      end
      if ((st_ff == rwlm_pkg::BE_DRAIN ||
           (st_ff == rwlm_pkg::BE_LOOK && lk_drain)) && out_free) begin
         rq_rd_ff <= rq_mem[maddr(ix_ff, rd_next)];
      end else begin
         rq_rd_ff <= rq_mem[maddr(ix_rd, rd_head_ff[ix_rd])];
      end
      wq_rd_ff <= wq_mem[maddr(ix_rd, wh_head_ff[ix_rd])];
      if (st_ff == rwlm_pkg::BE_LOOK && out_free && lk_enq_w) begin
         wq_mem[maddr(ix_ff, w_tail)] <= PID_BITS'(cur_ff.process_id);
      end
      if (st_ff == rwlm_pkg::BE_LOOK && out_free && lk_enq_r) begin
         rq_mem[maddr(ix_ff, r_tail)] <= PID_BITS'(cur_ff.process_id);
      end
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= rwlm_pkg::BE_IDLE;
         out_v_ff <= 1'b0;
         nlock_ff <= '0;
         for (int i = 0; i < NUM_LOCKS; i++) begin
            rc_ff[i] <= '0; wh_ff[i] <= 1'b0;
            wh_head_ff[i] <= '0; wc_ff[i] <= '0;
            rd_head_ff[i] <= '0; rcnt_ff[i] <= '0;
         end
      end else begin
         st_ff    <= st_in;
         out_v_ff <= out_v_in;
         nlock_ff <= nlock_in;
         if (st_ff == rwlm_pkg::BE_LOOK && out_free) begin
            if (lk_enq_w) wc_ff[ix_ff] <= wc_c + 1'b1;
            else if (lk_wake_w) begin
               wh_head_ff[ix_ff] <= (wh_h == QW'(QUEUE_DEPTH-1)) ? '0 : wh_h + 1'b1;
               wc_ff[ix_ff] <= wc_c - 1'b1;
            end
            if (lk_enq_r) rcnt_ff[ix_ff] <= rcn_c + 1'b1;
            if (lk_rc_inc) rc_ff[ix_ff] <= rc_c + 1'b1;
            else if (lk_rc_dec && !lk_drain) rc_ff[ix_ff] <= rc_c - 1'b1;
            if (lk_wh_set || lk_wake_w) wh_ff[ix_ff] <= 1'b1;
            else if (lk_wh_clr) wh_ff[ix_ff] <= 1'b0;
         end
         if ((st_ff == rwlm_pkg::BE_DRAIN ||
              (st_ff == rwlm_pkg::BE_LOOK && lk_drain)) && out_free) begin
            rd_head_ff[ix_ff] <= rd_next;
            rcnt_ff[ix_ff] <= rcn_c - 1'b1;
            if (rc_base < rwlm_pkg::RC_MAX) rc_ff[ix_ff] <= rc_base + 1'b1;
         end
      end
   end
endmodule

// ===== rtl/reader_writer_lock_manager.sv =====
// Top level of the reader-writer lock manager with writer preference.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | rwlm_pkg::req_type
//   rsp     | out       | rsp_valid/stall    | rwlm_pkg::rsp_type
//
// A request beat is registered into the back end and decided in the look state; its
// first result beat is then registered at the output, followed in turn by any further
// wake notices and the closing status, each held while the output stalls. A release that
// wakes n readers gives n + 1 beats. The back end handles one request at a time.
// Reset clears the lock table and queue pointers.
// A stalled result beat holds the back end; the front queue takes two more beats.
module reader_writer_lock_manager #(
   parameter int NUM_LOCKS   = 16,
   parameter int QUEUE_DEPTH = 8,
   parameter int PID_BITS    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rwlm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rwlm_pkg::rsp_type rsp_data
);
   logic              q_valid, q_take;
   rwlm_pkg::req_type q_data;

   rwlm_front #(.DEPTH(2)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_data
   );

   rwlm_back #(
      .NUM_LOCKS(NUM_LOCKS), .QUEUE_DEPTH(QUEUE_DEPTH), .PID_BITS(PID_BITS)
   ) u_back (
      .clock, .reset, .q_valid, .q_take, .q_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

// ===== rtl/rwlm_checker.sv =====
// Port-level checks for the reader-writer lock manager.
module rwlm_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rwlm_pkg::rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.kind == rwlm_pkg::KIND_FINAL) == rsp_data.last)
      else $error("last flag does not match kind");
   a_wake_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == rwlm_pkg::KIND_WAKE |-> rsp_data.status == rwlm_pkg::ST_OK)
      else $error("wake notice with non-ok status");
   a_final_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.woken_process == 8'd0 && !rsp_data.woken_mode)
      else $error("final beat carries a process");
endmodule

bind reader_writer_lock_manager rwlm_checker u_rwlm_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data
);

// ===== tb/tb_reader_writer_lock_manager.sv =====
// Self-checking testbench for the reader-writer lock manager with random stimulus and idling.
module tb_reader_writer_lock_manager;

   localparam int NLOCKS = 16;
   localparam int QDEPTH = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   rwlm_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rwlm_pkg::rsp_type rsp_data;

   reader_writer_lock_manager dut (.*);

   always #2 clock = ~clock;

   // Lock table mirror.
   int unsigned lock_count;
   int unsigned readers [NLOCKS];
   bit          writer_on [NLOCKS];
   logic [7:0]  wr_wait [NLOCKS][$];
   logic [7:0]  rd_wait [NLOCKS][$];

   rwlm_pkg::rsp_type pending_beats [$];
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      error_count = 0;
   int      beats_checked = 0;
   int      items_sent = 0;
   int      wake_count = 0;
   longint  cycle_count = 0;

   function automatic rwlm_pkg::rsp_type final_beat(logic [2:0] st, logic [4:0] lk);
      rwlm_pkg::rsp_type r;
      r = '0;
      r.kind = rwlm_pkg::KIND_FINAL;
      r.status = st;
      r.result_lock = lk;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic rwlm_pkg::rsp_type wake_beat(logic [4:0] lk, logic [7:0] pid, logic md);
      rwlm_pkg::rsp_type r;
      r = '0;
      r.kind = rwlm_pkg::KIND_WAKE;
      r.result_lock = lk;
      r.woken_process = pid;
      r.woken_mode = md;
      return r;
   endfunction

   function automatic logic [2:0] enqueue_waiter(int ix, logic md, logic [7:0] pid);
      if (md) begin
         if (wr_wait[ix].size() >= QDEPTH) return rwlm_pkg::ST_FULL;
         wr_wait[ix].push_back(pid);
      end else begin
         if (rd_wait[ix].size() >= QDEPTH) return rwlm_pkg::ST_FULL;
         rd_wait[ix].push_back(pid);
      end
      return rwlm_pkg::ST_QUEUED;
   endfunction

   function automatic void predict_lock_op(rwlm_pkg::req_type rq);
      int ix;
      logic [2:0] st;
      if (rq.action == rwlm_pkg::ACT_NEW) begin
         if (lock_count >= NLOCKS) pending_beats.push_back(final_beat(rwlm_pkg::ST_FULL, 5'd0));
         else begin
            lock_count++;
            pending_beats.push_back(final_beat(rwlm_pkg::ST_OK, 5'(lock_count)));
         end
         return;
      end
      if (rq.action != rwlm_pkg::ACT_ACQUIRE && rq.action != rwlm_pkg::ACT_RELEASE) begin
         pending_beats.push_back(final_beat(rwlm_pkg::ST_FULL, rq.lock_id));
         return;
      end
      if (rq.lock_id == 0 || rq.lock_id > lock_count) begin
         pending_beats.push_back(final_beat(rwlm_pkg::ST_NOTFOUND, rq.lock_id));
         return;
      end
      ix = rq.lock_id - 1;
      if (rq.action == rwlm_pkg::ACT_ACQUIRE) begin
         if (writer_on[ix] || wr_wait[ix].size() > 0)
            st = enqueue_waiter(ix, rq.lock_mode, rq.process_id);
         else if (!rq.lock_mode) begin
            if (readers[ix] >= rwlm_pkg::RC_MAX) st = rwlm_pkg::ST_FULL;
            else begin
               readers[ix]++;
               st = rwlm_pkg::ST_OK;
            end
         end else if (readers[ix] > 0) st = enqueue_waiter(ix, 1'b1, rq.process_id);
         else begin
            writer_on[ix] = 1'b1;
            st = rwlm_pkg::ST_OK;
         end
         pending_beats.push_back(final_beat(st, rq.lock_id));
         return;
      end
      if (!rq.lock_mode) begin
         if (readers[ix] == 0) begin
            pending_beats.push_back(final_beat(rwlm_pkg::ST_NOTHELD, rq.lock_id));
            return;
         end
         readers[ix]--;
      end else begin
         if (!writer_on[ix]) begin
            pending_beats.push_back(final_beat(rwlm_pkg::ST_NOTHELD, rq.lock_id));
            return;
         end
         writer_on[ix] = 1'b0;
      end
      if (readers[ix] == 0 && !writer_on[ix]) begin
         if (wr_wait[ix].size() > 0) begin
            writer_on[ix] = 1'b1;
            pending_beats.push_back(wake_beat(rq.lock_id, wr_wait[ix].pop_front(), 1'b1));
         end else begin
            while (rd_wait[ix].size() > 0) begin
               if (readers[ix] < rwlm_pkg::RC_MAX) readers[ix]++;
               pending_beats.push_back(wake_beat(rq.lock_id, rd_wait[ix].pop_front(), 1'b0));
            end
         end
      end
      pending_beats.push_back(final_beat(rwlm_pkg::ST_OK, rq.lock_id));
   endfunction

   task automatic send_beat(logic [1:0] act, logic [4:0] lk, logic md, logic [7:0] pid);
      rwlm_pkg::req_type rq;
      rq = '{action: act, lock_id: lk, lock_mode: md, process_id: pid};
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_lock_op(rq);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_beats.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset) rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (pending_beats.size() == 0) begin
            $error("unexpected result beat %p", rsp_data);
            error_count++;
         end else begin
            rwlm_pkg::rsp_type e;
            e = pending_beats.pop_front();
            if (e.kind == rwlm_pkg::KIND_WAKE) wake_count++;
            if (rsp_data.kind !== e.kind) begin
               $error("kind: expected %0d, actual %0d", e.kind, rsp_data.kind);
               error_count++;
            end
            if (rsp_data.status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.result_lock !== e.result_lock) begin
               $error("result_lock: expected %0d, actual %0d", e.result_lock,
                      rsp_data.result_lock);
               error_count++;
            end
            if (rsp_data.woken_process !== e.woken_process) begin
               $error("woken_process: expected %0d, actual %0d", e.woken_process,
                      rsp_data.woken_process);
               error_count++;
            end
            if (rsp_data.woken_mode !== e.woken_mode) begin
               $error("woken_mode: expected %0d, actual %0d", e.woken_mode,
                      rsp_data.woken_mode);
               error_count++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last: expected %0d, actual %0d", e.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed();
      send_beat(rwlm_pkg::ACT_ACQUIRE, 5'd1, 1'b0, 8'd1);
      send_beat(rwlm_pkg::ACT_RELEASE, 5'd0, 1'b1, 8'd2);
      send_beat(rwlm_pkg::ACT_NEW, 5'd31, 1'b1, 8'hff);
      send_beat(rwlm_pkg::ACT_NEW, 5'd0, 1'b0, 8'h00);
      send_beat(rwlm_pkg::ACT_ACQUIRE, 5'd1, 1'b0, 8'h11);
      send_beat(rwlm_pkg::ACT_ACQUIRE, 5'd1, 1'b0, 8'h12);
      send_beat(rwlm_pkg::ACT_ACQUIRE, 5'd1, 1'b1, 8'hff);
      send_beat(rwlm_pkg::ACT_ACQUIRE, 5'd1, 1'b0, 8'h00);
      send_beat(rwlm_pkg::ACT_ACQUIRE, 5'd1, 1'b0, 8'haa);
      send_beat(rwlm_pkg::ACT_RELEASE, 5'd1, 1'b1, 8'd0);
      send_beat(rwlm_pkg::ACT_RELEASE, 5'd1, 1'b0, 8'd0);
      send_beat(rwlm_pkg::ACT_RELEASE, 5'd1, 1'b0, 8'd0);
      send_beat(rwlm_pkg::ACT_RELEASE, 5'd1, 1'b1, 8'd0);
      send_beat(ACT_UNUSED, 5'd2, 1'b1, 8'h55);
      send_beat(rwlm_pkg::ACT_RELEASE, 5'd2, 1'b0, 8'd0);
      send_beat(rwlm_pkg::ACT_ACQUIRE, 5'd31, 1'b1, 8'd7);
      for (int k = 0; k < QDEPTH + 1; k++) begin
         send_beat(rwlm_pkg::ACT_ACQUIRE, 5'd2, 1'b1, 8'(k + 32));
      end
   endtask

   task automatic test_table_full();
      while (lock_count < NLOCKS) begin
         send_beat(rwlm_pkg::ACT_NEW, 5'($urandom), 1'($urandom), 8'($urandom));
      end
      send_beat(rwlm_pkg::ACT_NEW, 5'd16, 1'b1, 8'd0);
      send_beat(rwlm_pkg::ACT_ACQUIRE, 5'd16, 1'b1, 8'd9);
      send_beat(rwlm_pkg::ACT_ACQUIRE, 5'd17, 1'b0, 8'd9);
   endtask

   task automatic test_random(int n, int idle, int stall);
      int r;
      logic [4:0] lk;
      send_idle_pct = idle;
      stall_pct = stall;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         lk = 5'($urandom_range(1, 4));
         if (r < 4) lk = 5'($urandom);
         if (r < 2) send_beat(2'($urandom_range(0, 3)), lk, 1'($urandom), 8'($urandom));
         else if (r < 55) begin
            send_beat(rwlm_pkg::ACT_ACQUIRE, lk, 1'($urandom_range(99) < 35), 8'($urandom));
         end else if (r < 78) begin
            send_beat(rwlm_pkg::ACT_RELEASE, lk, writer_on[lk - 1], 8'($urandom));
         end else send_beat(rwlm_pkg::ACT_RELEASE, lk, 1'($urandom), 8'($urandom));
      end
      send_idle_pct = 0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      wait_drained();
      test_random(70, 0, 0);
      test_random(70, 61, 0);
      wait_drained();
      test_random(70, 0, 61);
      test_random(70, 18, 18);
      stall_pct = 0;
      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d request beats and checked %0d result beats, %0d of them wake notices.",
               items_sent, beats_checked, wake_count);
      if (error_count == 0 && pending_beats.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/rwlm_pkg.sv
rtl/rwlm_front.sv
rtl/rwlm_back.sv
rtl/reader_writer_lock_manager.sv
rtl/rwlm_checker.sv
tb/tb_reader_writer_lock_manager.sv
